// ----- rtl/bhcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bhcd_pkg
// Shared types and codes for the batch header conflict detector.
// ----------------------------------------------------------------------------
package bhcd_pkg;

  localparam int BATCH_W  = 64;
  localparam int DIGEST_W = 256;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 4;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EQUIV = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // lookup key, batch number in the low bits as on the input bus
  typedef struct packed {
    logic [DIGEST_W-1:0] digest;
    logic [BATCH_W-1:0]  batch;
  } key_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               found;
    logic               conflict;
    logic [INDEX_W-1:0] index;
  } tok_t;

endpackage
`default_nettype wire

// ----- rtl/bhcd_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bhcd_cell
// One table entry: holds a batch number and its digest, checks the passing
// search token against the key and hands the token on in the next cycle.
// ----------------------------------------------------------------------------
module bhcd_cell #(
  parameter int CELL_INDEX = 0,
  parameter int CNT_W      = 5
) (
  input  wire                 clk,
  input  wire                 rst,
  input  bhcd_pkg::key_t      key,
  input  wire [CNT_W-1:0]     count,
  input  wire                 wr_en,
  input  bhcd_pkg::tok_t      tok_in,
  output bhcd_pkg::tok_t      tok_out
);

  logic [bhcd_pkg::BATCH_W-1:0]  batch;
  logic [bhcd_pkg::DIGEST_W-1:0] digest;
  logic                          in_use;
  logic                          match;
  logic                          clash;
  bhcd_pkg::tok_t                tok_next;

  // entry holds data only once the fill count has passed it
  assign in_use = count > CNT_W'(CELL_INDEX);
  assign match  = tok_in.valid && !tok_in.found && in_use && (batch == key.batch);
  assign clash  = match && (digest != key.digest);

  // token update
  always_comb begin
    tok_next          = tok_in;
    tok_next.found    = tok_in.found | match;
    tok_next.conflict = tok_in.conflict | clash;
    if (clash) begin
      tok_next.index = CELL_INDEX[bhcd_pkg::INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // append writes the entry at the fill position
  always_ff @(posedge clk) begin
    if (wr_en && (count == CNT_W'(CELL_INDEX))) begin
      batch  <= key.batch;
      digest <= key.digest;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/batch_header_conflict_detector_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// batch_header_conflict_detector_top
// Equivocation check of sealed batch headers against a table of earlier ones.
// ----------------------------------------------------------------------------
// Each accepted item carries a batch number and its 256-bit header digest.
// A search token walks a row of MAX_RECORDS cells, one cell per cycle, and
// the first cell holding the same batch number decides: same digest gives
// ok, a different digest gives equivocation with that entry's index and sets
// the sticky halted flag. A new number is appended when room is left, else
// the result is table full. One item is in work at a time: the token passes
// the launch register and the cell row, the end token is held in pend, and
// the result is loaded into the output register once the output is free;
// the next item is accepted from the following cycle on, while that result may
// still wait to be taken.
module batch_header_conflict_detector_top #(
  parameter int MAX_RECORDS = 16
) (
  input  wire          clk,
  input  wire          rst,
  // s_tdata: batch_seq, digest_word0, digest_word1, digest_word2,
  //          digest_word3 (lowest bit up)
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire [319:0]  s_tdata,
  // m_tdata: status[1:0], conflict_index[5:2], halted[6], zero[7]
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [7:0]   m_tdata
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                            state;
  state_t                            state_next;
  bhcd_pkg::key_t                    key;
  bhcd_pkg::tok_t                    chain [MAX_RECORDS+1];
  bhcd_pkg::tok_t                    pend;
  logic                              launch;
  logic [CNT_W-1:0]                  entry_count;
  logic                              halt_flag;
  logic                              halt_next;
  logic                              s_accept;
  logic                              out_free;
  logic                              finish;
  logic                              full;
  logic                              append;
  logic [bhcd_pkg::STATUS_W-1:0]     status_next;
  logic [bhcd_pkg::STATUS_W-1:0]     res_status;
  logic [bhcd_pkg::INDEX_W-1:0]      res_index;
  logic                              res_halted;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == S_DONE) && out_free;
  assign full     = (entry_count == CNT_W'(MAX_RECORDS));
  assign append   = finish && !pend.found && !full;

  // item key, held for the whole search
  always_ff @(posedge clk) begin
    if (s_accept) begin
      key <= s_tdata;
    end
  end

  // token enters the first cell once the key is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= s_accept;
    end
  end

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
  end

  // row of table cells
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    bhcd_cell #(
      .CELL_INDEX (i),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .key     (key),
      .count   (entry_count),
      .wr_en   (append),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // token at the end of the row
  always_ff @(posedge clk) begin
    if (chain[MAX_RECORDS].valid) begin
      pend <= chain[MAX_RECORDS];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chain[MAX_RECORDS].valid) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result decode
  always_comb begin
    if (pend.found) begin
      status_next = pend.conflict ? bhcd_pkg::STATUS_EQUIV : bhcd_pkg::STATUS_OK;
    end else begin
      status_next = full ? bhcd_pkg::STATUS_FULL : bhcd_pkg::STATUS_OK;
    end
  end

  assign halt_next = halt_flag | (pend.found && pend.conflict);

  // fill count and sticky halt
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      halt_flag   <= 1'b0;
    end else begin
      if (append) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (finish) begin
        halt_flag <= halt_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res_status <= status_next;
      res_index  <= (pend.found && pend.conflict) ? pend.index : '0;
      res_halted <= halt_next;
    end
  end

  assign m_tdata = {1'b0, res_halted, res_index, res_status};

`ifndef SYNTH
  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_RECORDS))
    else $error("entry count beyond table size");

  // halt flag is sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag cleared without reset");

  // fill count only grows one entry per item
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (entry_count != $past(entry_count))
      |-> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("entry count jumped");

  // equivocation result always reports halted
  a_equiv_halted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_status == bhcd_pkg::STATUS_EQUIV) |-> res_halted)
    else $error("equivocation without halt");

  // conflict index is zero unless equivocation
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_status != bhcd_pkg::STATUS_EQUIV) |-> res_index == '0)
    else $error("conflict index set without equivocation");
`endif

endmodule
`default_nettype wire
